// ===== src/k_way_sorted_run_merge_macros.svh =====
// ----------------------------------------------------------------------------
// k_way_sorted_run_merge_macros
// Assertion macros used by the checker of the sorted run merge.
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_RUN_MERGE_MACROS_SVH
`define K_WAY_SORTED_RUN_MERGE_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define KWSRM_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("kwsrm assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define KWSRM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("kwsrm assertion failed");

`endif

// ===== src/kwsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsrm_pkg
// Types, codes and sizes of the sorted run merge.
// ----------------------------------------------------------------------------
package kwsrm_pkg;

   localparam int WAYS        = 8;
   localparam int RUN_DEPTH   = 256;
   localparam int QUEUE_DEPTH = 2;

   localparam int WIDX_W = $clog2(WAYS);
   localparam int PTR_W  = $clog2(RUN_DEPTH + 1);
   localparam int ADDR_W = $clog2(WAYS * RUN_DEPTH);
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_POP   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         way;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic [2:0]         source_way;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_LOAD,
      OP_POP,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               way_ok;
      logic [2:0]         way;
      logic signed [31:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_DONE
   } state_type;

endpackage

// ===== src/kwsrm_front.sv =====
// ----------------------------------------------------------------------------
// kwsrm_front
// Accepts requests, decodes them into commands and queues them for the back.
// ----------------------------------------------------------------------------
module kwsrm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  kwsrm_pkg::req_type req_data,
   output logic               cmd_valid,
   input  logic               cmd_take,
   output kwsrm_pkg::cmd_type cmd
);

   kwsrm_pkg::cmd_type                q_ff [kwsrm_pkg::QUEUE_DEPTH];
   logic [kwsrm_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [kwsrm_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [kwsrm_pkg::QCNT_W-1:0]      count_ff, count_in;
   kwsrm_pkg::cmd_type                cls;
   logic                              push;
   logic                              pop;

   always_comb begin
      cls.way    = req_data.way;
      cls.value  = req_data.value;
      cls.way_ok = (32'(req_data.way) < kwsrm_pkg::WAYS);
      unique case (req_data.kind)
         kwsrm_pkg::KIND_CLEAR: cls.op = kwsrm_pkg::OP_CLEAR;
         kwsrm_pkg::KIND_LOAD:  cls.op = kwsrm_pkg::OP_LOAD;
         kwsrm_pkg::KIND_POP:   cls.op = kwsrm_pkg::OP_POP;
         default:               cls.op = kwsrm_pkg::OP_NOP;
      endcase
   end

   assign req_stall = (count_ff == kwsrm_pkg::QCNT_W'(kwsrm_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_valid && cmd_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == kwsrm_pkg::QPTR_W'(kwsrm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == kwsrm_pkg::QPTR_W'(kwsrm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== src/kwsrm_back.sv =====
// ----------------------------------------------------------------------------
// kwsrm_back
// Executes clear, load and pop commands against the run store and drives
// the registered response.
// ----------------------------------------------------------------------------
module kwsrm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_take,
   input  kwsrm_pkg::cmd_type cmd,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output kwsrm_pkg::rsp_type rsp_data
);

   logic signed [31:0]              store [kwsrm_pkg::WAYS * kwsrm_pkg::RUN_DEPTH];
   logic [kwsrm_pkg::PTR_W-1:0]     len_ff [kwsrm_pkg::WAYS];
   logic [kwsrm_pkg::PTR_W-1:0]     ptr_ff [kwsrm_pkg::WAYS];

   kwsrm_pkg::state_type            state_ff, state_in;
   logic [kwsrm_pkg::WIDX_W-1:0]    scan_ff;
   logic [kwsrm_pkg::WIDX_W-1:0]    best_ff;
   logic signed [31:0]              best_val_ff;
   logic                            found_ff;
   logic                            rd_vld_ff;
   logic [kwsrm_pkg::WIDX_W-1:0]    rd_way_ff;
   logic signed [31:0]              rd_data_ff;
   kwsrm_pkg::rsp_type              rsp_ff, rsp_in;
   logic                            rsp_valid_ff;

   logic                            out_free;
   logic [kwsrm_pkg::WIDX_W-1:0]    idx;
   logic [kwsrm_pkg::PTR_W-1:0]     cur_len;
   logic [kwsrm_pkg::PTR_W-1:0]     cur_ptr;
   logic [kwsrm_pkg::ADDR_W-1:0]    base_addr;
   logic [kwsrm_pkg::ADDR_W-1:0]    wr_addr;
   logic [kwsrm_pkg::ADDR_W-1:0]    rd_addr;
   logic                            clr_all;
   logic                            wr_en;
   logic                            ptr_inc;
   logic                            rd_en;
   logic                            start;
   logic                            rsp_load;
   logic                            last_way;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_way  = (scan_ff == kwsrm_pkg::WIDX_W'(kwsrm_pkg::WAYS - 1));
   assign cur_len   = len_ff[idx];
   assign cur_ptr   = ptr_ff[idx];
   assign base_addr = kwsrm_pkg::ADDR_W'(idx) * kwsrm_pkg::ADDR_W'(kwsrm_pkg::RUN_DEPTH);
   assign wr_addr   = base_addr + kwsrm_pkg::ADDR_W'(cur_len);
   assign rd_addr   = base_addr + kwsrm_pkg::ADDR_W'(cur_ptr);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kwsrm_pkg::S_IDLE: begin
            if (cmd_valid && cmd.op == kwsrm_pkg::OP_POP) begin
               state_in = kwsrm_pkg::S_SCAN;
            end
         end
         kwsrm_pkg::S_SCAN: begin
            if (last_way) begin
               state_in = kwsrm_pkg::S_LAST;
            end
         end
         kwsrm_pkg::S_LAST: state_in = kwsrm_pkg::S_DONE;
         kwsrm_pkg::S_DONE: begin
            if (out_free) begin
               state_in = kwsrm_pkg::S_IDLE;
            end
         end
         default: state_in = kwsrm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      idx      = best_ff;
      cmd_take = 1'b0;
      clr_all  = 1'b0;
      wr_en    = 1'b0;
      ptr_inc  = 1'b0;
      rd_en    = 1'b0;
      start    = 1'b0;
      rsp_load = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         kwsrm_pkg::S_IDLE: begin
            idx      = kwsrm_pkg::WIDX_W'(cmd.way);
            cmd_take = cmd_valid && (cmd.op == kwsrm_pkg::OP_POP || out_free);
            if (cmd_take) begin
               unique case (cmd.op)
                  kwsrm_pkg::OP_CLEAR: begin
                     clr_all  = 1'b1;
                     rsp_load = 1'b1;
                  end
                  kwsrm_pkg::OP_LOAD: begin
                     rsp_load = 1'b1;
                     if (cmd.way_ok &&
                         cur_len < kwsrm_pkg::PTR_W'(kwsrm_pkg::RUN_DEPTH)) begin
                        wr_en = 1'b1;
                     end else begin
                        rsp_in.status = kwsrm_pkg::STATUS_DROPPED;
                     end
                  end
                  kwsrm_pkg::OP_POP: start = 1'b1;
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         kwsrm_pkg::S_SCAN: begin
            idx   = scan_ff;
            rd_en = (cur_ptr < cur_len);
         end
         kwsrm_pkg::S_LAST: idx = best_ff;
         kwsrm_pkg::S_DONE: begin
            idx = best_ff;
            if (out_free) begin
               rsp_load = 1'b1;
               if (found_ff) begin
                  ptr_inc           = 1'b1;
                  rsp_in.out_value  = best_val_ff;
                  rsp_in.source_way = 3'(best_ff);
                  rsp_in.status     = kwsrm_pkg::STATUS_OK;
               end else begin
                  rsp_in.status = kwsrm_pkg::STATUS_EMPTY;
               end
            end
         end
         default: idx = best_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwsrm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         scan_ff      <= '0;
         for (int i = 0; i < kwsrm_pkg::WAYS; i++) begin
            len_ff[i] <= '0;
            ptr_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         rd_vld_ff    <= rd_en;
         if (start) begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            if (state_ff == kwsrm_pkg::S_SCAN && !last_way) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (rd_vld_ff && (!found_ff || rd_data_ff < best_val_ff)) begin
               found_ff <= 1'b1;
            end
         end
         if (clr_all) begin
            for (int i = 0; i < kwsrm_pkg::WAYS; i++) begin
               len_ff[i] <= '0;
               ptr_ff[i] <= '0;
            end
         end else begin
            if (wr_en) begin
               len_ff[idx] <= cur_len + 1'b1;
            end
            if (ptr_inc) begin
               ptr_ff[idx] <= cur_ptr + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (rd_en) begin
         rd_way_ff <= idx;
      end
      if (!start && rd_vld_ff && (!found_ff || rd_data_ff < best_val_ff)) begin
         best_ff     <= rd_way_ff;
         best_val_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/k_way_sorted_run_merge.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_run_merge
// Merges sorted runs of signed 32-bit values by linear minimum selection.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_stall   kwsrm_pkg::req_type
//   rsp       out         rsp_valid / rsp_stall   kwsrm_pkg::rsp_type
//
// A clear or load passes through the command queue and is then executed in
// the execution unit, which registers its response. A pop scans the run
// heads way by way through the single read port of the store.
// Reset empties every run at once; the store itself needs no clearing pass.
// A stalled response holds while the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module k_way_sorted_run_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  kwsrm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output kwsrm_pkg::rsp_type rsp_data
);

   logic               cmd_valid;
   logic               cmd_take;
   kwsrm_pkg::cmd_type cmd;

   kwsrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   kwsrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/kwsrm_checker.sv =====
// ----------------------------------------------------------------------------
// kwsrm_checker
// Port-level checks of the sorted run merge, bound to the top level.
// ----------------------------------------------------------------------------
`include "k_way_sorted_run_merge_macros.svh"

module kwsrm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input kwsrm_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input kwsrm_pkg::rsp_type rsp_data
);

   logic out_zero;
   logic out_empty;
   logic out_dropped;
   logic out_status_known;

   assign out_zero         = (rsp_data.out_value == 32'sd0) && (rsp_data.source_way == 3'd0);
   assign out_empty        = (rsp_data.status == kwsrm_pkg::STATUS_EMPTY);
   assign out_dropped      = (rsp_data.status == kwsrm_pkg::STATUS_DROPPED);
   assign out_status_known = (rsp_data.status == kwsrm_pkg::STATUS_OK) ||
                             out_empty || out_dropped;

   `KWSRM_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_data))
   `KWSRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `KWSRM_ASSERT_SAME(a_status_code, rsp_valid, out_status_known)
   `KWSRM_ASSERT_SAME(a_empty_zero, rsp_valid && out_empty, out_zero)
   `KWSRM_ASSERT_SAME(a_drop_zero, rsp_valid && out_dropped, out_zero)

endmodule

bind k_way_sorted_run_merge kwsrm_checker u_kwsrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
